/* hw/rtl/wildcard_pattern_matcher_defines.svh */
// ----------------------------------------------------------------------------
// wildcard pattern matcher assertion macros
// shared concurrent assertion forms, all disabled while the active-low reset is low
// ----------------------------------------------------------------------------
`ifndef WILDCARD_PATTERN_MATCHER_DEFINES_SVH
`define WILDCARD_PATTERN_MATCHER_DEFINES_SVH

// condition holds at every edge outside reset
`define WPM_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define WPM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define WPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hw/rtl/wpm_pkg.sv */
// ----------------------------------------------------------------------------
// wpm_pkg
// shared types and constants of the wildcard pattern matcher
// ----------------------------------------------------------------------------
`default_nettype none

package wpm_pkg;

  // default pattern capacity
  localparam int MAX_PATTERN_DEF = 32;

  // special pattern bytes
  localparam logic [7:0] STAR_CODE  = 8'h2A;
  localparam logic [7:0] QMARK_CODE = 8'h3F;

  // item opcodes
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_START  = 2'd2,
    OP_TEXT   = 2'd3
  } op_t;

  // control broadcast from the top level to every cell
  typedef struct packed {
    logic       load;      // reload the empty-text column
    logic       text;      // advance the column by one text byte
    logic       append;    // pattern byte append transfer
    logic [7:0] char_code;
  } cell_ctrl_t;

  // digits and ascii letters
  function automatic logic is_alnum(input logic [7:0] b);
    is_alnum = ((b >= 8'h30) && (b <= 8'h39)) ||
               ((b >= 8'h41) && (b <= 8'h5A)) ||
               ((b >= 8'h61) && (b <= 8'h7A));
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/wpm_if.sv */
// ----------------------------------------------------------------------------
// wpm channel interfaces
// valid/ready channels for the input items and the result items
// ----------------------------------------------------------------------------
`default_nettype none

// input item channel
interface wpm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] char_code;

  modport source (output valid, output opcode, output char_code, input ready);
  modport sink   (input valid, input opcode, input char_code, output ready);
endinterface

// result item channel
interface wpm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_overflow;

  modport source (output valid, output matched, output pattern_overflow, input ready);
  modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

`default_nettype wire

/* hw/rtl/wildcard_pattern_matcher.sv */
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher
// streams text bytes against a stored wildcard pattern, one column per byte
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries items: clear pattern, append pattern byte, start text,
//          text byte. Clear and append give no result; start text and text
//          byte each give one result on out_ch (matched, pattern_overflow).
//   Throughput is one item per cycle while out_ch is not stalled. Every
//   item updates the whole chain of cells in its transfer cycle; a run of
//   star cells ripples through the chain, and that ripple sets the cycle.
//   Latency: a result is valid in the cycle after its item's transfer.
//   in_ch.ready is low only while a result waits in the output register
//   and out_ch.ready is low; no item is lost or repeated under stalls.
//   Reset empties the pattern, clears the overflow flag and sets the
//   column to the empty-pattern state. Pattern bytes are not cleared;
//   only bytes below the pattern length are ever used.
//   Appends beyond MAX_PATTERN are dropped and raise pattern_overflow
//   until the next clear.
// ----------------------------------------------------------------------------
`default_nettype none

`include "wildcard_pattern_matcher_defines.svh"

module wildcard_pattern_matcher #(
  parameter int MAX_PATTERN = wpm_pkg::MAX_PATTERN_DEF
) (
  input  wire   clk,
  input  wire   rst_n,
  wpm_in_if.sink    in_ch,
  wpm_out_if.source out_ch
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  wpm_pkg::op_t        op;
  wpm_pkg::cell_ctrl_t ctrl;
  logic                fire;
  logic                gives_result;
  logic                col0_r;
  logic                col0_nxt;
  logic [LEN_W-1:0]    len_r;
  logic [LEN_W-1:0]    len_nxt;
  logic                ovf_r;
  logic                ovf_nxt;
  logic [MAX_PATTERN:0] col_old;
  logic [MAX_PATTERN:0] col_new;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic                matched_r;
  logic                ovf_out_r;

  // input transfer
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign fire        = in_ch.valid && in_ch.ready;
  assign op          = wpm_pkg::op_t'(in_ch.opcode);

  // opcode decode
  always_comb begin
    ctrl.load      = 1'b0;
    ctrl.text      = 1'b0;
    ctrl.append    = 1'b0;
    ctrl.char_code = in_ch.char_code;
    gives_result   = 1'b0;
    len_nxt        = len_r;
    ovf_nxt        = ovf_r;
    if (fire) begin
      case (op)
        wpm_pkg::OP_CLEAR: begin
          ctrl.load = 1'b1;
          len_nxt   = '0;
          ovf_nxt   = 1'b0;
        end
        wpm_pkg::OP_APPEND: begin
          ctrl.load = 1'b1;
          if (len_r < LEN_W'(MAX_PATTERN)) begin
            ctrl.append = 1'b1;
            len_nxt     = len_r + LEN_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        wpm_pkg::OP_START: begin
          ctrl.load    = 1'b1;
          gives_result = 1'b1;
        end
        wpm_pkg::OP_TEXT: begin
          ctrl.text    = 1'b1;
          gives_result = 1'b1;
        end
        default: begin
          ctrl.load = 1'b0;
        end
      endcase
    end
  end

  // column bit zero: empty pattern matches only the empty text
  assign col_old[0] = col0_r;
  assign col_new[0] = ctrl.load;
  assign col0_nxt   = (ctrl.load || ctrl.text) ? col_new[0] : col0_r;

  // chain of pattern cells
  for (genvar i = 1; i <= MAX_PATTERN; i++) begin : g_cell
    wpm_cell #(
      .INDEX (i),
      .LEN_W (LEN_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .len_r    (len_r),
      .len_nxt  (len_nxt),
      .old_left (col_old[i-1]),
      .new_left (col_new[i-1]),
      .old_bit  (col_old[i]),
      .new_bit  (col_new[i])
    );
  end

  // output register
  always_comb begin
    if (gives_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.matched          = matched_r;
  assign out_ch.pattern_overflow = ovf_out_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col0_r      <= 1'b1;
      len_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      col0_r      <= col0_nxt;
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (gives_result) begin
      matched_r <= col_new[len_nxt];
      ovf_out_r <= ovf_nxt;
    end
  end

  // checks
  `WPM_ASSERT_ALWAYS(a_len_bound, clk, rst_n, len_r <= LEN_W'(MAX_PATTERN))
  `WPM_ASSERT_NEXT(a_text_clears_col0, clk, rst_n, fire && (op == wpm_pkg::OP_TEXT), !col0_r)
  `WPM_ASSERT_NEXT(a_load_sets_col0, clk, rst_n, fire && (op != wpm_pkg::OP_TEXT), col0_r)
  `WPM_ASSERT_SAME(a_result_source, clk, rst_n, $rose(out_valid_r), $past(fire) && ($past(op) == wpm_pkg::OP_START || $past(op) == wpm_pkg::OP_TEXT))

endmodule

`default_nettype wire

/* hw/rtl/wpm_cell.sv */
// ----------------------------------------------------------------------------
// wpm_cell
// one pattern position: holds its pattern byte and its match bit
// ----------------------------------------------------------------------------
`default_nettype none

module wpm_cell #(
  parameter int INDEX = 1,
  parameter int LEN_W = 6
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire wpm_pkg::cell_ctrl_t ctrl,
  input  wire logic [LEN_W-1:0]   len_r,
  input  wire logic [LEN_W-1:0]   len_nxt,
  input  wire logic               old_left,
  input  wire logic               new_left,
  output logic                    old_bit,
  output logic                    new_bit
);

  logic [7:0] pat_r;
  logic       match_r;
  logic       match_nxt;
  logic       wr_en;
  logic [7:0] pat_eff;
  logic       active;
  logic       is_star;
  logic       is_qmark;

  // pattern byte write at the current tail
  assign wr_en   = ctrl.append && (len_r == LEN_W'(INDEX - 1));
  assign pat_eff = wr_en ? ctrl.char_code : pat_r;
  assign active  = (len_nxt >= LEN_W'(INDEX));
  assign is_star  = (pat_eff == wpm_pkg::STAR_CODE);
  assign is_qmark = (pat_eff == wpm_pkg::QMARK_CODE);

  // new column bit; star cells ripple from the left neighbour's new bit
  always_comb begin
    new_bit = 1'b0;
    if (active) begin
      if (ctrl.load) begin
        new_bit = is_star && new_left;
      end else if (is_qmark) begin
        new_bit = wpm_pkg::is_alnum(ctrl.char_code) && old_left;
      end else if (is_star) begin
        new_bit = new_left || match_r;
      end else begin
        new_bit = (pat_eff == ctrl.char_code) && old_left;
      end
    end
  end

  assign match_nxt = (ctrl.load || ctrl.text) ? new_bit : match_r;
  assign old_bit   = match_r;

  // pattern byte, no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      pat_r <= ctrl.char_code;
    end
  end

  // match bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

endmodule

`default_nettype wire
